>>> hw/rtl/vau_pkg.sv
// Shared types, opcodes and status codes for the three-component vector ALU.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
package vau_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DW            = 32;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_SCALE = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_CROSS = 3'd4;
    localparam logic [2:0] OP_DOT   = 3'd5;
    localparam logic [2:0] OP_LEN   = 3'd6;
    localparam logic [2:0] OP_UNIT  = 3'd7;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    localparam logic [DW-1:0] POS_MAX = 32'h7fff_ffff;
    localparam logic [DW-1:0] NEG_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [2:0]          operation;
        logic signed [31:0]  a_x;
        logic signed [31:0]  a_y;
        logic signed [31:0]  a_z;
        logic signed [31:0]  b_x;
        logic signed [31:0]  b_y;
        logic signed [31:0]  b_z;
        logic signed [31:0]  scalar_in;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0]  res_x;
        logic signed [31:0]  res_y;
        logic signed [31:0]  res_z;
        logic signed [31:0]  res_scalar;
        logic [1:0]          status;
    } t_out_beat;

    // operands of one lane: p1 = x1*y1, p2 = x2*y2, plus the add/sub pair
    typedef struct packed {
        logic [DW-1:0] x1;
        logic [DW-1:0] y1;
        logic [DW-1:0] x2;
        logic [DW-1:0] y2;
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        logic          sub;
        logic          is_as;
    } t_lane_op;

    typedef struct packed {
        logic [2:0]         op;
        logic [2:0][DW-1:0] a;
        logic [DW-1:0]      s;
    } t_ctl;

    typedef struct packed {
        logic [2:0]         op;
        logic [2:0][DW-1:0] a;
        logic [DW-1:0]      s;
        logic [2:0][DW-1:0] v;
        logic               vsat;
        logic [DW-1:0]      dot;
        logic               dsat;
    } t_mid;

    typedef struct packed {
        t_mid          m;
        logic [DW-1:0] len;
    } t_fin;

endpackage

>>> hw/rtl/vau_if.sv
// Valid/ready channel interfaces for the vector ALU input and result beats.
// Depends on vau_pkg for the beat types.
`timescale 1ns / 1ps
interface vau_in_if;
    logic               valid;
    logic               ready;
    vau_pkg::t_in_beat  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface vau_out_if;
    logic               valid;
    logic               ready;
    vau_pkg::t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/vau_lane.sv
// One component lane: two registered 32x32 products, add/sub, and the
// rounded, saturated result for add, sub, scale and cross. Uses vau_pkg.
`timescale 1ns / 1ps
module vau_lane #(
    parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  vau_pkg::t_lane_op       i_op,
    output logic signed [63:0]      o_p1,
    output logic [vau_pkg::DW-1:0]  o_res,
    output logic                    o_sat
);
    import vau_pkg::*;

    localparam logic [64:0] HALF = 65'd1 << (FRAC_BITS - 1);

    logic signed [63:0] r_p1, r_p2;
    logic [32:0]        r_as;
    logic               r_is_as;
    logic [DW-1:0]      r_res;
    logic               r_sat;

    logic [32:0] n_as;
    logic [64:0] diff, rnd, sh;
    logic        as_sat, p_sat;

    always_comb begin
        n_as = i_op.sub ? {i_op.a[31], i_op.a} - {i_op.b[31], i_op.b}
                        : {i_op.a[31], i_op.a} + {i_op.b[31], i_op.b};
        diff = {r_p1[63], r_p1} - {r_p2[63], r_p2};
        rnd  = diff + HALF;
        sh   = 65'($signed(rnd) >>> FRAC_BITS);
        p_sat  = !((&sh[64:31]) || !(|sh[64:31]));
        as_sat = r_as[32] != r_as[31];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1    <= $signed(i_op.x1) * $signed(i_op.y1);
            r_p2    <= $signed(i_op.x2) * $signed(i_op.y2);
            r_as    <= n_as;
            r_is_as <= i_op.is_as;
            if (r_is_as) begin
                r_res <= as_sat ? (r_as[32] ? NEG_MIN : POS_MAX) : r_as[31:0];
                r_sat <= as_sat;
            end else begin
                r_res <= p_sat ? (sh[64] ? NEG_MIN : POS_MAX) : sh[31:0];
                r_sat <= p_sat;
            end
        end
    end

    assign o_p1  = r_p1;
    assign o_res = r_res;
    assign o_sat = r_sat;

endmodule

>>> hw/rtl/vau_sqrt.sv
// Pipelined restoring square root of a 64-bit sum, one result bit per stage,
// rounded to nearest in a final stage. Uses vau_pkg.
`timescale 1ns / 1ps
module vau_sqrt (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [63:0]             i_x,
    output logic [vau_pkg::DW-1:0]  o_len
);
    import vau_pkg::*;

    localparam int ITERS = 32;

    logic [32:0]   r_rem  [ITERS];
    logic [31:0]   r_root [ITERS];
    logic [63:0]   r_x    [ITERS-1];
    logic [DW-1:0] r_len;

    for (genvar k = 0; k < ITERS; k++) begin : g_stage
        logic [32:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] x_in;
        logic [34:0] t, trial;
        logic        ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = i_x;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign x_in    = r_x[k-1];
        end

        assign t     = {rem_in, x_in[63:62]};
        assign trial = {1'b0, root_in, 2'b01};
        assign ge    = t >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? 33'(t - trial) : t[32:0];
                r_root[k] <= {root_in[30:0], ge};
            end
        end

        if (k < ITERS - 1) begin : g_shift
            always_ff @(posedge i_clk) begin
                if (i_en) r_x[k] <= {x_in[61:0], 2'b00};
            end
        end
    end

    // round up when the remainder exceeds the floor root
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len <= r_root[ITERS-1]
                   + DW'(r_rem[ITERS-1] > {1'b0, r_root[ITERS-1]});
        end
    end

    assign o_len = r_len;

endmodule

>>> hw/rtl/vau_div.sv
// Pipelined restoring divider for one lane: |num| << FRAC_BITS by a 32-bit
// magnitude, one quotient bit per stage, then round, sign and clamp. Uses vau_pkg.
`timescale 1ns / 1ps
module vau_div #(
    parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [vau_pkg::DW-1:0]  i_num,
    input  logic [vau_pkg::DW-1:0]  i_den,
    input  logic                    i_neg,
    output logic [vau_pkg::DW-1:0]  o_q,
    output logic                    o_sat
);
    import vau_pkg::*;

    localparam int NW = DW + FRAC_BITS;
    localparam logic [NW:0] LIM_POS = {{(NW-30){1'b0}}, {31{1'b1}}};
    localparam logic [NW:0] LIM_NEG = {{(NW-31){1'b0}}, 1'b1, {31{1'b0}}};

    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_nq  [NW];
    logic [DW-1:0] r_den [NW];
    logic          r_sgn [NW];
    logic [DW-1:0] r_q;
    logic          r_sat;

    logic [DW-1:0] mag;
    assign mag = i_num[DW-1] ? DW'(-i_num) : i_num;

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DW-1:0] rem_in, den_in;
        logic [NW-1:0] nq_in;
        logic          sgn_in;
        logic [DW:0]   t;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = {mag, {FRAC_BITS{1'b0}}};
            assign den_in = i_den;
            assign sgn_in = i_num[DW-1] ^ i_neg;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign nq_in  = r_nq[k-1];
            assign den_in = r_den[k-1];
            assign sgn_in = r_sgn[k-1];
        end

        assign t  = {rem_in, nq_in[NW-1]};
        assign ge = t >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? DW'(t - {1'b0, den_in}) : t[DW-1:0];
                r_nq[k]  <= {nq_in[NW-2:0], ge};
                r_den[k] <= den_in;
                r_sgn[k] <= sgn_in;
            end
        end
    end

    logic          up;
    logic [NW:0]   q1;
    logic          sat_p, sat_n;

    always_comb begin
        up    = {r_rem[NW-1], 1'b0} >= {1'b0, r_den[NW-1]};
        q1    = {1'b0, r_nq[NW-1]} + (NW+1)'(up);
        sat_p = q1 > LIM_POS;
        sat_n = q1 > LIM_NEG;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_sgn[NW-1]) begin
                r_q   <= sat_n ? NEG_MIN : (~q1[DW-1:0] + DW'(1));
                r_sat <= sat_n;
            end else begin
                r_q   <= sat_p ? POS_MAX : q1[DW-1:0];
                r_sat <= sat_p;
            end
        end
    end

    assign o_q   = r_q;
    assign o_sat = r_sat;

endmodule

>>> hw/rtl/vec3_arithmetic_unit.sv
// Data path: Q16.16 at the default FRAC_BITS; an input beat passes the lanes, the merge,
// the 32-stage square root and then the (32 + FRAC_BITS)-stage divider.
// Throughput: one beat per cycle; the whole pipeline holds while a result waits.
// Reset: synchronous, active low; clears the valid bits only, input not ready while held.
// Depends on vau_pkg, vau_if, vau_lane, vau_sqrt and vau_div.
`timescale 1ns / 1ps
module vec3_arithmetic_unit #(
    parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    vau_in_if.sink    i_in,
    vau_out_if.source o_out
);
    import vau_pkg::*;

    localparam int NW      = DW + FRAC_BITS;
    localparam int SQ_LAT  = 33;
    localparam int D1      = SQ_LAT - 1;
    localparam int DIV_LAT = NW + 1;
    localparam int P       = 3 + D1 + DIV_LAT;
    localparam logic [65:0] HALF = 66'd1 << (FRAC_BITS - 1);

    logic en;
    assign en        = !o_out.valid || o_out.ready;
    // hold off input beats while reset is held
    assign i_in.ready = en && i_rst_n;

    // operand routing per lane
    logic [2:0][DW-1:0] a, b;
    t_lane_op           lop [3];
    logic [2:0]         op;

    always_comb begin
        op = i_in.data.operation;
        a  = {i_in.data.a_z, i_in.data.a_y, i_in.data.a_x};
        b  = {i_in.data.b_z, i_in.data.b_y, i_in.data.b_x};
        for (int i = 0; i < 3; i++) begin
            int j, k;
            j = (i == 2) ? 0 : i + 1;
            k = (i == 0) ? 2 : i - 1;
            lop[i].a     = a[i];
            lop[i].b     = b[i];
            lop[i].sub   = op == OP_SUB;
            lop[i].is_as = (op == OP_ADD) || (op == OP_SUB);
            lop[i].x1    = a[i];
            lop[i].y1    = b[i];
            lop[i].x2    = '0;
            lop[i].y2    = '0;
            unique case (op)
                OP_SCALE: lop[i].y1 = i_in.data.scalar_in;
                OP_CROSS: begin
                    lop[i].x1 = a[j];
                    lop[i].y1 = b[k];
                    lop[i].x2 = a[k];
                    lop[i].y2 = b[j];
                end
                OP_LEN, OP_UNIT: lop[i].y1 = a[i];
                default: ;
            endcase
        end
    end

    logic signed [63:0] p1 [3];
    logic [DW-1:0]      lres [3];
    logic               lsat [3];

    for (genvar g = 0; g < 3; g++) begin : g_lane
        vau_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_op  (lop[g]),
            .o_p1  (p1[g]),
            .o_res (lres[g]),
            .o_sat (lsat[g])
        );
    end

    // merge: sum of the three lane products (dot or sum of squares)
    t_ctl        r_c1, r_c2;
    logic [65:0] r_sum2;
    t_mid        r_mid;
    logic [65:0] drnd, dsh;
    logic        dsat;

    always_comb begin
        drnd = r_sum2 + HALF;
        dsh  = 66'($signed(drnd) >>> FRAC_BITS);
        dsat = !((&dsh[65:31]) || !(|dsh[65:31]));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1   <= '{op: op, a: a, s: i_in.data.scalar_in};
            r_c2   <= r_c1;
            r_sum2 <= 66'(p1[0]) + 66'(p1[1]) + 66'(p1[2]);
            r_mid.op   <= r_c2.op;
            r_mid.a    <= r_c2.a;
            r_mid.s    <= r_c2.s;
            r_mid.v    <= {lres[2], lres[1], lres[0]};
            r_mid.vsat <= lsat[0] | lsat[1] | lsat[2];
            r_mid.dot  <= dsat ? (dsh[65] ? NEG_MIN : POS_MAX) : dsh[31:0];
            r_mid.dsat <= dsat;
        end
    end

    logic [DW-1:0] len;
    vau_sqrt u_sqrt (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r_sum2[63:0]),
        .o_len (len)
    );

    // align the merged beat with the square root
    t_mid r_d1 [D1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1[0] <= r_mid;
            for (int i = 1; i < D1; i++) r_d1[i] <= r_d1[i-1];
        end
    end

    t_mid          m35;
    logic [DW-1:0] den, smag;
    logic          dneg;
    assign m35  = r_d1[D1-1];
    assign smag = m35.s[DW-1] ? DW'(-m35.s) : m35.s;
    assign den  = (m35.op == OP_UNIT) ? len : smag;
    assign dneg = (m35.op == OP_DIV) && m35.s[DW-1];

    logic [DW-1:0] dq [3];
    logic          dqs [3];
    for (genvar g = 0; g < 3; g++) begin : g_div
        vau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (m35.a[g]),
            .i_den (den),
            .i_neg (dneg),
            .o_q   (dq[g]),
            .o_sat (dqs[g])
        );
    end

    t_fin r_d2 [DIV_LAT];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d2[0] <= '{m: m35, len: len};
            for (int i = 1; i < DIV_LAT; i++) r_d2[i] <= r_d2[i-1];
        end
    end

    // final selection per opcode
    t_fin      f;
    t_out_beat n_out;
    logic      any_dsat;

    always_comb begin
        f        = r_d2[DIV_LAT-1];
        any_dsat = dqs[0] | dqs[1] | dqs[2];
        n_out    = '0;
        unique case (f.m.op)
            OP_ADD, OP_SUB, OP_SCALE, OP_CROSS: begin
                n_out.res_x  = f.m.v[0];
                n_out.res_y  = f.m.v[1];
                n_out.res_z  = f.m.v[2];
                n_out.status = f.m.vsat ? ST_SAT : ST_OK;
            end
            OP_DIV: begin
                if (f.m.s == '0) begin
                    n_out.res_x  = f.m.a[0][DW-1] ? NEG_MIN : ((|f.m.a[0]) ? POS_MAX : '0);
                    n_out.res_y  = f.m.a[1][DW-1] ? NEG_MIN : ((|f.m.a[1]) ? POS_MAX : '0);
                    n_out.res_z  = f.m.a[2][DW-1] ? NEG_MIN : ((|f.m.a[2]) ? POS_MAX : '0);
                    n_out.status = ST_DIVZ;
                end else begin
                    n_out.res_x  = dq[0];
                    n_out.res_y  = dq[1];
                    n_out.res_z  = dq[2];
                    n_out.status = any_dsat ? ST_SAT : ST_OK;
                end
            end
            OP_DOT: begin
                n_out.res_scalar = f.m.dot;
                n_out.status     = f.m.dsat ? ST_SAT : ST_OK;
            end
            OP_LEN: begin
                n_out.res_scalar = f.len[DW-1] ? POS_MAX : f.len;
                n_out.status     = f.len[DW-1] ? ST_SAT : ST_OK;
            end
            OP_UNIT: begin
                if (f.len == '0) begin
                    n_out.status = ST_DIVZ;
                end else begin
                    n_out.res_x  = dq[0];
                    n_out.res_y  = dq[1];
                    n_out.res_z  = dq[2];
                    n_out.status = any_dsat ? ST_SAT : ST_OK;
                end
            end
            default: ;
        endcase
    end

    // valid bits travel alongside the payload
    logic [P-1:0] r_vld;
    logic         r_ov;
    t_out_beat    r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ov  <= 1'b0;
        end else if (en) begin
            r_vld <= {r_vld[P-2:0], i_in.valid};
            r_ov  <= r_vld[P-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_out <= n_out;
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

`ifndef SYNTHESIS
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.data.status != 2'd3)
        else $error("status code out of range");
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while result stalled");
    a_divz_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.status == ST_DIVZ) |-> o_out.data.res_scalar == '0)
        else $error("divide by zero on a scalar result");
    a_beat_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[0])
        else $error("accepted beat lost at pipeline entry");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for vec3_arithmetic_unit: random and directed vector operations,
// predicted in fixed point and compared beat by beat. Depends on vau_pkg, vau_if and vec3_arithmetic_unit.
`timescale 1ns / 1ps
module tb;
    import vau_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam longint LIM_HI = 64'sd2147483647;
    localparam longint LIM_LO = -64'sd2147483648;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    vau_in_if  in_if ();
    vau_out_if out_if ();

    vec3_arithmetic_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_in_beat  pending_ops[$];
    t_out_beat expected_res[$];
    int        n_fail = 0;
    int        n_sent = 0;
    int        n_got = 0;
    int        in_gap = 0;
    int        out_gap = 0;
    bit        calm = 1'b0;

    function automatic longint sat32(input logic signed [127:0] v, inout bit sat);
        if (v > LIM_HI) begin
            sat = 1'b1;
            return LIM_HI;
        end
        if (v < LIM_LO) begin
            sat = 1'b1;
            return LIM_LO;
        end
        return longint'(v);
    endfunction

    // product sum rescaled by 2^FB, nearest with ties upward
    function automatic logic signed [127:0] rescale(input logic signed [127:0] sum);
        logic signed [127:0] half;
        half = 128'sd1 <<< (FB - 1);
        return (sum + half) >>> FB;
    endfunction

    // quotient num*2^FB / d, nearest with ties away from zero
    function automatic logic signed [127:0] fx_quot(input longint num,
                                                    input longint unsigned d,
                                                    input bit dneg);
        longint unsigned n, q, r;
        n = (num < 0 ? longint'(-num) : num) << FB;
        q = n / d;
        r = n % d;
        if (r >= d - r) q++;
        if ((num < 0) != dneg) return -$signed({64'd0, q});
        return $signed({64'd0, q});
    endfunction

    function automatic longint unsigned root_round(input longint unsigned x);
        longint unsigned root, b2;
        root = 0;
        b2 = 64'd1 << 62;
        while (b2 > x) b2 >>= 2;
        while (b2 != 0) begin
            if (x >= root + b2) begin
                x -= root + b2;
                root = (root >> 1) + b2;
            end else begin
                root >>= 1;
            end
            b2 >>= 2;
        end
        if (x > root) root++;
        return root;
    endfunction

    function automatic t_out_beat vec_result(input t_in_beat it);
        t_out_beat o;
        longint a[3], b[3], v[3], s, sc;
        longint unsigned sq, len;
        logic signed [127:0] acc;
        bit sat;
        logic [1:0] st;
        int j, k;
        a[0] = it.a_x; a[1] = it.a_y; a[2] = it.a_z;
        b[0] = it.b_x; b[1] = it.b_y; b[2] = it.b_z;
        s = it.scalar_in;
        v = '{0, 0, 0};
        sc = 0;
        sat = 1'b0;
        st = ST_OK;
        case (it.operation)
            OP_ADD: for (int i = 0; i < 3; i++) v[i] = sat32(a[i] + b[i], sat);
            OP_SUB: for (int i = 0; i < 3; i++) v[i] = sat32(a[i] - b[i], sat);
            OP_SCALE: for (int i = 0; i < 3; i++) v[i] = sat32(rescale(a[i] * s), sat);
            OP_DIV: begin
                if (s == 0) begin
                    for (int i = 0; i < 3; i++)
                        v[i] = a[i] > 0 ? LIM_HI : (a[i] < 0 ? LIM_LO : 0);
                    st = ST_DIVZ;
                end else begin
                    for (int i = 0; i < 3; i++)
                        v[i] = sat32(fx_quot(a[i], s < 0 ? -s : s, s < 0), sat);
                end
            end
            OP_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    j = (i + 1) % 3;
                    k = (i + 2) % 3;
                    acc = 128'(a[j] * b[k]) - 128'(a[k] * b[j]);
                    v[i] = sat32(rescale(acc), sat);
                end
            end
            OP_DOT: begin
                acc = 128'(a[0] * b[0]) + 128'(a[1] * b[1]) + 128'(a[2] * b[2]);
                sc = sat32(rescale(acc), sat);
            end
            default: begin
                sq = 0;
                for (int i = 0; i < 3; i++) sq += longint'(a[i] * a[i]);
                len = root_round(sq);
                if (it.operation == OP_LEN) sc = sat32($signed({64'd0, len}), sat);
                else if (len == 0) st = ST_DIVZ;
                else for (int i = 0; i < 3; i++) v[i] = sat32(fx_quot(a[i], len, 1'b0), sat);
            end
        endcase
        if (st == ST_OK && sat) st = ST_SAT;
        o.res_x = v[0][31:0];
        o.res_y = v[1][31:0];
        o.res_z = v[2][31:0];
        o.res_scalar = sc[31:0];
        o.status = st;
        return o;
    endfunction

    // mix of full-range, small and extreme operands
    function automatic logic [31:0] pick_val();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3:       return ($urandom_range(0, 1)) ? POS_MAX : NEG_MIN;
            4:       return 32'd0;
            5:       return 32'(int'($urandom_range(0, 8)) - 4) <<< FB;
            default: return 32'(int'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000);
        endcase
    endfunction

    function automatic t_in_beat mk(input logic [2:0] op, input logic [31:0] ax, ay, az,
                                    bx, by, bz, sv);
        t_in_beat it;
        it.operation = op;
        it.a_x = ax; it.a_y = ay; it.a_z = az;
        it.b_x = bx; it.b_y = by; it.b_z = bz;
        it.scalar_in = sv;
        return it;
    endfunction

    initial begin
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
    end

    // driver: advance to the next beat once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                expected_res.push_back(vec_result(in_if.data));
                n_sent++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_if.valid <= 1'b0;
                end else if (pending_ops.size() > 0 && !calm && $urandom_range(0, 7) == 0) begin
                    in_gap = $urandom_range(0, 3);
                    in_if.valid <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    in_if.data <= pending_ops.pop_front();
                    in_if.valid <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result beat against the oldest prediction
    always @(posedge i_clk) begin
        t_out_beat e;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                n_got++;
                if (expected_res.size() == 0) begin
                    $error("result beat with nothing expected");
                    n_fail++;
                end else begin
                    e = expected_res.pop_front();
                    if (out_if.data.res_x !== e.res_x) begin
                        $error("res_x expected %h got %h", e.res_x, out_if.data.res_x);
                        n_fail++;
                    end
                    if (out_if.data.res_y !== e.res_y) begin
                        $error("res_y expected %h got %h", e.res_y, out_if.data.res_y);
                        n_fail++;
                    end
                    if (out_if.data.res_z !== e.res_z) begin
                        $error("res_z expected %h got %h", e.res_z, out_if.data.res_z);
                        n_fail++;
                    end
                    if (out_if.data.res_scalar !== e.res_scalar) begin
                        $error("res_scalar expected %h got %h", e.res_scalar,
                               out_if.data.res_scalar);
                        n_fail++;
                    end
                    if (out_if.data.status !== e.status) begin
                        $error("status expected %0d got %0d", e.status, out_if.data.status);
                        n_fail++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                out_if.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_gap = $urandom_range(0, 3);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [31:0] one;
        one = 32'd1 << FB;
        // extremes, every operation, divide by zero, unit of zero, rounding ties
        pending_ops.push_back(mk(OP_ADD, POS_MAX, NEG_MIN, 0, 1, NEG_MIN, 0, 0));
        pending_ops.push_back(mk(OP_SUB, NEG_MIN, POS_MAX, one, 1, NEG_MIN, 0, 0));
        pending_ops.push_back(mk(OP_SCALE, POS_MAX, NEG_MIN, 32'h8000, 0, 0, 0, NEG_MIN));
        pending_ops.push_back(mk(OP_SCALE, 32'h1, 32'hffff_ffff, 32'h3, 0, 0, 0, 32'h8000));
        pending_ops.push_back(mk(OP_SCALE, one, -one, 5, 0, 0, 0, one * 3));
        pending_ops.push_back(mk(OP_DIV, one, -one, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk(OP_DIV, POS_MAX, NEG_MIN, 3, 0, 0, 0, 1));
        pending_ops.push_back(mk(OP_DIV, one, 32'hffff_fffd, 7, 0, 0, 0, one * 2));
        pending_ops.push_back(mk(OP_DIV, NEG_MIN, 1, -one, 0, 0, 0, NEG_MIN));
        pending_ops.push_back(mk(OP_CROSS, one, 0, 0, 0, one, 0, 0));
        pending_ops.push_back(mk(OP_CROSS, POS_MAX, NEG_MIN, POS_MAX, NEG_MIN, POS_MAX,
                                 NEG_MIN, 0));
        pending_ops.push_back(mk(OP_DOT, one, one, one, one * 2, -one, 3, 0));
        pending_ops.push_back(mk(OP_DOT, NEG_MIN, NEG_MIN, NEG_MIN, NEG_MIN, NEG_MIN,
                                 NEG_MIN, 0));
        pending_ops.push_back(mk(OP_DOT, 32'h1, 32'h1, 0, 32'h8000, 32'h8000, 0, 0));
        pending_ops.push_back(mk(OP_LEN, one * 3, one * 4, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk(OP_LEN, NEG_MIN, NEG_MIN, NEG_MIN, 0, 0, 0, 0));
        pending_ops.push_back(mk(OP_LEN, 0, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk(OP_UNIT, 0, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk(OP_UNIT, 1, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk(OP_UNIT, NEG_MIN, POS_MAX, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk(OP_UNIT, one, one, one, 0, 0, 0, 0));
        for (int n = 0; n < 1500; n++)
            pending_ops.push_back(mk(3'($urandom_range(0, 7)), pick_val(), pick_val(),
                                     pick_val(), pick_val(), pick_val(), pick_val(),
                                     pick_val()));
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_ops.size() > 0 || in_if.valid || expected_res.size() > 0) begin
            @(posedge i_clk);
            calm <= pending_ops.size() < 150;
        end
        repeat (120) @(posedge i_clk);
        $display("Sent %0d operation beats (all eight opcodes, extremes, divide by zero),",
                 n_sent);
        $display("checked %0d result beats with random stalls on both channels.", n_got);
        if (n_fail == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
